@@ src/ipss_pkg.sv @@
// Package for the IUPAC PAM site scanner: constants, base codes, result types
// and the small helper functions used by the window and match stages.
// No dependencies.
`default_nettype none

package ipss_pkg;

    localparam int PROTOSPACER_LEN = 20;
    localparam int MAX_PAM_LEN     = 8;
    localparam int WIN_DEPTH       = PROTOSPACER_LEN + MAX_PAM_LEN;

    localparam int CODE_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 32;
    localparam int PATTERN_W = 32;
    localparam int MASK_W    = 4;
    localparam int LEN_W     = 4;
    localparam int LM1_W     = $clog2(MAX_PAM_LEN);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int PAM_W     = CODE_W * MAX_PAM_LEN;
    localparam int PROTO_W   = CODE_W * PROTOSPACER_LEN;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAM_PATTERN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAM_LENGTH  = 1'b1;

    localparam logic [PATTERN_W-1:0] PAM_PATTERN_RESET = 32'd1103;
    localparam logic [LEN_W-1:0]     PAM_LENGTH_RESET  = 4'd3;

    // base codes
    localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_G = 8'h47;
    localparam logic [BYTE_W-1:0] CHAR_T = 8'h54;

    localparam logic [MASK_W-1:0] MASK_ANY = 4'hF;

    localparam logic STRAND_PLUS  = 1'b0;
    localparam logic STRAND_MINUS = 1'b1;

    typedef logic [WIN_DEPTH-1:0][CODE_W-1:0] window_t;

    typedef struct packed {
        logic                 strand;
        logic [POS_W-1:0]     position;
        logic [PAM_W-1:0]     pam_bases;
        logic [PROTO_W-1:0]   protospacer;
    } result_t;

    typedef struct packed {
        logic    plus_hit;
        logic    minus_hit;
        result_t plus_res;
        result_t minus_res;
    } match_t;

    function automatic logic [CODE_W-1:0] encode_base(input logic [BYTE_W-1:0] b);
        logic [CODE_W-1:0] c;
        case (b)
            CHAR_A:  c = CODE_A;
            CHAR_C:  c = CODE_C;
            CHAR_G:  c = CODE_G;
            CHAR_T:  c = CODE_T;
            default: c = CODE_OTHER;
        endcase
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] comp_code(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] r;
        if (c < CODE_OTHER)
            r = CODE_T - c;
        else
            r = CODE_OTHER;
        return r;
    endfunction

    // anything that is not A/C/G/T only matches the full wildcard
    function automatic logic code_matches(input logic [CODE_W-1:0] c,
                                          input logic [MASK_W-1:0] mask);
        logic m;
        if (c < CODE_OTHER)
            m = mask[c[1:0]];
        else
            m = (mask == MASK_ANY);
        return m;
    endfunction

endpackage

`default_nettype wire

@@ src/ipss_in_if.sv @@
// Input channel of the PAM site scanner: one sequence byte per transaction.
// Uses ipss_pkg for widths.
`default_nettype none

interface ipss_in_if;
    logic                        valid;
    logic                        ready;
    logic [ipss_pkg::BYTE_W-1:0] base;
    logic                        first;

    modport source (output valid, output base, output first, input ready);
    modport sink   (input valid, input base, input first, output ready);
endinterface

`default_nettype wire

@@ src/ipss_out_if.sv @@
// Result channel of the PAM site scanner: one hit per transaction.
// Uses ipss_pkg for widths.
`default_nettype none

interface ipss_out_if;
    logic                         valid;
    logic                         ready;
    logic                         strand;
    logic [ipss_pkg::POS_W-1:0]   position;
    logic [ipss_pkg::PAM_W-1:0]   pam_bases;
    logic [ipss_pkg::PROTO_W-1:0] protospacer;
    logic                         last;

    modport source (output valid, output strand, output position, output pam_bases,
                    output protospacer, output last, input ready);
    modport sink   (input valid, input strand, input position, input pam_bases,
                    input protospacer, input last, output ready);
endinterface

`default_nettype wire

@@ src/ipss_cfg_if.sv @@
// Configuration write channel of the PAM site scanner.
// Uses ipss_pkg for the index and data widths.
`default_nettype none

interface ipss_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ipss_pkg::CFG_IDX_W-1:0]  index;
    logic [ipss_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/iupac_pam_site_scanner.sv @@
// Top level of the IUPAC PAM site scanner: configuration registers, window,
// match logic and result register. Depends on ipss_pkg, the channel interfaces,
// ipss_window, ipss_match and ipss_out_buf.
//
// One base is taken per transaction and one can be taken every cycle unless the
// hits of the base under test wait for a full result register. The base enters
// the window shift line at acceptance; in the next cycle the site ending at that
// base is checked on both strands and any hits move to the result register once
// it is free, from where they are offered on the result port. The result port
// moves one hit per cycle while ready is high, so a base that hits on both
// strands occupies it for two transactions, plus first, with last set on the
// second; bases with at most one hit stream at full rate while results are
// taken every cycle. Configuration writes are taken every cycle and should be
// made only while no hits are outstanding.
`default_nettype none

module iupac_pam_site_scanner (
    input  wire          clk,
    input  wire          rst_n,
    ipss_in_if.sink      bases,
    ipss_out_if.source   hits,
    ipss_cfg_if.sink     cfg
);

    logic [ipss_pkg::PATTERN_W-1:0] pam_pattern_reg;
    logic [ipss_pkg::LEN_W-1:0]     pam_length_reg;

    ipss_pkg::window_t              win;
    logic [ipss_pkg::POS_W-1:0]     pos;
    logic [ipss_pkg::FILL_W-1:0]    fill;
    ipss_pkg::match_t               hit;

    logic s1_valid_reg, s1_valid_next;
    logic in_take, buf_free, s1_done, load;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pam_pattern_reg <= ipss_pkg::PAM_PATTERN_RESET;
            pam_length_reg  <= ipss_pkg::PAM_LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ipss_pkg::CFG_PAM_PATTERN: pam_pattern_reg <= cfg.data;
                ipss_pkg::CFG_PAM_LENGTH:  pam_length_reg  <= cfg.data[ipss_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // the window holds the item under test until its hits are handed over
    assign load    = s1_valid_reg && (hit.plus_hit || hit.minus_hit) && buf_free;
    assign s1_done = !s1_valid_reg || !(hit.plus_hit || hit.minus_hit) || buf_free;
    assign bases.ready = s1_done;
    assign in_take = bases.valid && s1_done;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_done)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    ipss_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_take),
        .base     (bases.base),
        .first    (bases.first),
        .win      (win),
        .pos      (pos),
        .fill     (fill)
    );

    ipss_match u_match (
        .win         (win),
        .pos         (pos),
        .fill        (fill),
        .pam_pattern (pam_pattern_reg),
        .pam_length  (pam_length_reg),
        .res         (hit)
    );

    ipss_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .hit   (hit),
        .free  (buf_free),
        .hits  (hits)
    );

endmodule

`default_nettype wire

@@ src/ipss_window.sv @@
// Base window shift line with forward position and fill count.
// Depends on ipss_pkg.
`default_nettype none

module ipss_window (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             shift_en,
    input  wire  [ipss_pkg::BYTE_W-1:0]     base,
    input  wire                             first,
    output ipss_pkg::window_t               win,
    output logic [ipss_pkg::POS_W-1:0]      pos,
    output logic [ipss_pkg::FILL_W-1:0]     fill
);

    ipss_pkg::window_t               win_reg, win_next;
    logic [ipss_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [ipss_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic                            restart;

    // a new chromosome (or the very first base) flushes the window
    assign restart = first || (fill_reg == '0);

    always_comb
    begin
        win_next  = win_reg;
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (shift_en)
        begin
            for (int k = ipss_pkg::WIN_DEPTH - 1; k > 0; k--)
            begin
                win_next[k] = restart ? ipss_pkg::CODE_OTHER : win_reg[k-1];
            end
            win_next[0] = ipss_pkg::encode_base(base);
            if (restart)
            begin
                pos_next  = '0;
                fill_next = ipss_pkg::FILL_W'(1);
            end
            else
            begin
                pos_next = pos_reg + ipss_pkg::POS_W'(1);
                if (fill_reg < ipss_pkg::FILL_W'(ipss_pkg::WIN_DEPTH))
                    fill_next = fill_reg + ipss_pkg::FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= {ipss_pkg::WIN_DEPTH{ipss_pkg::CODE_OTHER}};
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
        end
    end

    assign win  = win_reg;
    assign pos  = pos_reg;
    assign fill = fill_reg;

endmodule

`default_nettype wire

@@ src/ipss_match.sv @@
// PAM match on both strands for the site that ends at the newest base,
// with packing of PAM and protospacer codes. Depends on ipss_pkg.
`default_nettype none

module ipss_match (
    input  ipss_pkg::window_t                  win,
    input  wire  [ipss_pkg::POS_W-1:0]         pos,
    input  wire  [ipss_pkg::FILL_W-1:0]        fill,
    input  wire  [ipss_pkg::PATTERN_W-1:0]     pam_pattern,
    input  wire  [ipss_pkg::LEN_W-1:0]         pam_length,
    output ipss_pkg::match_t                   res
);

    logic [ipss_pkg::LEN_W-1:0]  eff_len;
    logic [ipss_pkg::LM1_W-1:0]  lm1;
    logic                        full;
    logic                        plus_ok, minus_ok;
    logic [ipss_pkg::CODE_W-1:0] pc, mc;
    logic [ipss_pkg::MASK_W-1:0] lane;
    logic [ipss_pkg::PAM_W-1:0]  plus_pam, minus_pam;
    logic [ipss_pkg::PROTO_W-1:0] plus_proto, minus_proto;

    always_comb
    begin
        if (pam_length == '0)
            eff_len = ipss_pkg::LEN_W'(1);
        else if (pam_length > ipss_pkg::LEN_W'(ipss_pkg::MAX_PAM_LEN))
            eff_len = ipss_pkg::LEN_W'(ipss_pkg::MAX_PAM_LEN);
        else
            eff_len = pam_length;
        lm1  = ipss_pkg::LM1_W'(eff_len - ipss_pkg::LEN_W'(1));
        full = (fill >= ipss_pkg::FILL_W'(eff_len) +
                        ipss_pkg::FILL_W'(ipss_pkg::PROTOSPACER_LEN));

        plus_ok   = 1'b1;
        minus_ok  = 1'b1;
        plus_pam  = '0;
        minus_pam = '0;
        for (int j = 0; j < ipss_pkg::MAX_PAM_LEN; j++)
        begin
            lane = pam_pattern[ipss_pkg::MASK_W*j +: ipss_pkg::MASK_W];
            // plus PAM base j sits at window place lm1 - j
            pc = ipss_pkg::CODE_OTHER;
            for (int m = j; m < ipss_pkg::MAX_PAM_LEN; m++)
            begin
                if (int'(lm1) == m)
                    pc = win[m-j];
            end
            mc = ipss_pkg::comp_code(win[ipss_pkg::PROTOSPACER_LEN + j]);
            if (j <= int'(lm1))
            begin
                if (!ipss_pkg::code_matches(pc, lane))
                    plus_ok = 1'b0;
                if (!ipss_pkg::code_matches(mc, lane))
                    minus_ok = 1'b0;
                plus_pam[ipss_pkg::CODE_W*j +: ipss_pkg::CODE_W]  = pc;
                minus_pam[ipss_pkg::CODE_W*j +: ipss_pkg::CODE_W] = mc;
            end
        end

        plus_proto  = '0;
        minus_proto = '0;
        for (int j = 0; j < ipss_pkg::PROTOSPACER_LEN; j++)
        begin
            for (int m = 0; m < ipss_pkg::MAX_PAM_LEN; m++)
            begin
                if (int'(lm1) == m)
                    plus_proto[ipss_pkg::CODE_W*j +: ipss_pkg::CODE_W] =
                        win[m + ipss_pkg::PROTOSPACER_LEN - j];
            end
            minus_proto[ipss_pkg::CODE_W*j +: ipss_pkg::CODE_W] =
                ipss_pkg::comp_code(win[j]);
        end

        res.plus_hit              = full && plus_ok;
        res.minus_hit             = full && minus_ok;
        res.plus_res.strand       = ipss_pkg::STRAND_PLUS;
        res.plus_res.position     = pos - ipss_pkg::POS_W'(lm1);
        res.plus_res.pam_bases    = plus_pam;
        res.plus_res.protospacer  = plus_proto;
        res.minus_res.strand      = ipss_pkg::STRAND_MINUS;
        res.minus_res.position    = pos - ipss_pkg::POS_W'(ipss_pkg::PROTOSPACER_LEN);
        res.minus_res.pam_bases   = minus_pam;
        res.minus_res.protospacer = minus_proto;
    end

endmodule

`default_nettype wire

@@ src/ipss_out_buf.sv @@
// Result register holding the plus and minus hits of one base and handing
// them out in order, plus first. Depends on ipss_pkg and ipss_out_if.
`default_nettype none

module ipss_out_buf (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               load,
    input  ipss_pkg::match_t  hit,
    output logic              free,
    ipss_out_if.source        hits
);

    logic [1:0]         pend_reg, pend_next;   // bit0 plus, bit1 minus
    ipss_pkg::result_t  plus_reg, minus_reg;
    ipss_pkg::result_t  head;
    logic               take;

    assign take = hits.valid && hits.ready;
    assign head = pend_reg[0] ? plus_reg : minus_reg;

    // free when empty, or once this transaction drains the last pending hit
    assign free = (pend_reg == 2'b00) ||
                  (take && ((pend_reg == 2'b01) || (pend_reg == 2'b10)));

    always_comb
    begin
        pend_next = pend_reg;
        if (take)
        begin
            if (pend_reg[0])
                pend_next[0] = 1'b0;
            else
                pend_next[1] = 1'b0;
        end
        if (load)
            pend_next = {hit.minus_hit, hit.plus_hit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'b00;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plus_reg  <= hit.plus_res;
            minus_reg <= hit.minus_res;
        end
    end

    assign hits.valid       = |pend_reg;
    assign hits.strand      = head.strand;
    assign hits.position    = head.position;
    assign hits.pam_bases   = head.pam_bases;
    assign hits.protospacer = head.protospacer;
    assign hits.last        = pend_reg[0] ? !pend_reg[1] : 1'b1;

endmodule

`default_nettype wire
